>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, sampled on clock, off during reset.
`define SHC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define SHC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/shc_pkg.sv
package shc_pkg;

   localparam int TRIG_BITS = 16;
   localparam int HIT_BITS  = 16;

   localparam logic [1:0] FAM_V4 = 2'd0;
   localparam logic [1:0] FAM_V6 = 2'd1;

   localparam logic [1:0] VERDICT_BELOW = 2'd0;
   localparam logic [1:0] VERDICT_TRIG  = 2'd1;
   localparam logic [1:0] VERDICT_ERR   = 2'd2;

   typedef struct packed {
      logic [1:0]  family;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
   } shc_req_type;

   typedef struct packed {
      logic [1:0]          verdict;
      logic [HIT_BITS-1:0] hit_count;
   } shc_rsp_type;

endpackage

>>> rtl/core/shc_ram.sv
module shc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/source_hit_counter_with_trigger_top.sv
// Per-source hit counter. Each request word names an IPv4 or IPv6 source; the
// block finds it in that family's table (a synchronous RAM of TABLE_ENTRIES
// words, key and count side by side), inserts it with count one if absent
// (evicting the oldest insertion once the table is full), bumps the count
// with saturation and answers triggered once the count reaches trigger_count.
// Words are handled one at a time. The table RAM is scanned one entry per
// cycle through its single read port up to a hit or past every filled entry;
// a zero threshold (triggered) or an unsupported family (error) skips the scan.
// Tables are empty right after reset (tracked by fill counts, no clearing
// pass). The user must write trigger_count through the csr port only while
// the block is idle; the block itself does not enforce it.
`include "assert_macros.svh"

module source_hit_counter_with_trigger_top
   import shc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256,
   parameter int COUNT_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  shc_req_type          req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output shc_rsp_type          rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TRIG_BITS-1:0] csr_data
);

   localparam int AW  = $clog2(TABLE_ENTRIES);
   localparam int FW  = $clog2(TABLE_ENTRIES + 1);
   localparam int W4  = 32 + COUNT_BITS;
   localparam int W6  = 128 + COUNT_BITS;
   localparam logic [AW-1:0]         LAST_SLOT = AW'(TABLE_ENTRIES - 1);
   localparam logic [FW-1:0]         FULL      = FW'(TABLE_ENTRIES);
   localparam logic [COUNT_BITS-1:0] CMAX      = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type              state_ff, state_in;
   shc_req_type            req_ff, req_in;
   logic [TRIG_BITS-1:0]   trig_ff, trig_in;
   logic [FW-1:0]          v4_fill_ff, v4_fill_in, v6_fill_ff, v6_fill_in;
   logic [AW-1:0]          v4_oldest_ff, v4_oldest_in, v6_oldest_ff, v6_oldest_in;
   logic [FW-1:0]          issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          chk_ff, chk_in;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                   wr_ff, wr_in;
   shc_rsp_type            res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   shc_rsp_type            rsp_word_ff, rsp_word_in;

   logic                   is_v6;
   logic [FW-1:0]          fill_sel;
   logic [AW-1:0]          oldest_sel;
   logic [AW-1:0]          oldest_next;
   logic [AW-1:0]          new_slot;
   logic                   hit;
   logic [COUNT_BITS-1:0]  rd_cnt;
   logic [COUNT_BITS-1:0]  bumped;
   logic [31:0]            cnt_wide;
   logic                   out_free;

   logic                   rd4_en, rd6_en, wr4_en, wr6_en;
   logic [W4-1:0]          rd4_data;
   logic [W6-1:0]          rd6_data;

   shc_ram #(.WIDTH(W4), .DEPTH(TABLE_ENTRIES)) u_v4_ram (
      .clock   (clock),
      .wr_en   (wr4_en),
      .wr_addr (slot_ff),
      .wr_data ({req_ff.addr_lo[31:0], bumped}),
      .rd_en   (rd4_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd4_data)
   );

   shc_ram #(.WIDTH(W6), .DEPTH(TABLE_ENTRIES)) u_v6_ram (
      .clock   (clock),
      .wr_en   (wr6_en),
      .wr_addr (slot_ff),
      .wr_data ({req_ff.addr_hi, req_ff.addr_lo, bumped}),
      .rd_en   (rd6_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd6_data)
   );

   always_comb begin
      is_v6      = (req_ff.family == FAM_V6);
      fill_sel   = is_v6 ? v6_fill_ff : v4_fill_ff;
      oldest_sel = is_v6 ? v6_oldest_ff : v4_oldest_ff;
      oldest_next = (oldest_sel == LAST_SLOT) ? '0 : oldest_sel + AW'(1);
      new_slot   = (fill_sel < FULL) ? fill_sel[AW-1:0] : oldest_sel;
      if (is_v6) begin
         hit    = (rd6_data[W6-1:COUNT_BITS] == {req_ff.addr_hi, req_ff.addr_lo});
         rd_cnt = rd6_data[COUNT_BITS-1:0];
      end else begin
         hit    = (rd4_data[W4-1:COUNT_BITS] == req_ff.addr_lo[31:0]);
         rd_cnt = rd4_data[COUNT_BITS-1:0];
      end
      bumped   = (cnt_ff != CMAX) ? cnt_ff + COUNT_BITS'(1) : cnt_ff;
      cnt_wide = 32'(bumped);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      trig_in      = csr_valid ? csr_data : trig_ff;
      v4_fill_in   = v4_fill_ff;
      v6_fill_in   = v6_fill_ff;
      v4_oldest_in = v4_oldest_ff;
      v6_oldest_in = v6_oldest_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      chk_in       = chk_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      wr_in        = wr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rd4_en       = 1'b0;
      rd6_en       = 1'b0;
      wr4_en       = 1'b0;
      wr6_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               issue_in = '0;
               wr_in    = 1'b0;
               priority if (trig_ff == '0) begin
                  res_in   = '{verdict: VERDICT_TRIG, hit_count: '0};
                  state_in = ST_WRITE;
               end else if (req_word.family != FAM_V4 && req_word.family != FAM_V6) begin
                  res_in   = '{verdict: VERDICT_ERR, hit_count: '0};
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // reads run one ahead of the compare
            if (pend_ff && hit) begin
               slot_in  = chk_ff;
               cnt_in   = rd_cnt;
               wr_in    = 1'b1;
               state_in = ST_WRITE;
            end else if (issue_ff == fill_sel) begin
               // miss: claim a slot, evicting the oldest once full
               slot_in  = new_slot;
               cnt_in   = '0;
               wr_in    = 1'b1;
               state_in = ST_WRITE;
               if (fill_sel < FULL) begin
                  if (is_v6) begin
                     v6_fill_in = v6_fill_ff + FW'(1);
                  end else begin
                     v4_fill_in = v4_fill_ff + FW'(1);
                  end
               end else if (is_v6) begin
                  v6_oldest_in = oldest_next;
               end else begin
                  v4_oldest_in = oldest_next;
               end
            end else begin
               rd4_en   = !is_v6;
               rd6_en   = is_v6;
               pend_in  = 1'b1;
               chk_in   = issue_ff[AW-1:0];
               issue_in = issue_ff + FW'(1);
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               wr4_en       = wr_ff && !is_v6;
               wr6_en       = wr_ff && is_v6;
               rsp_valid_in = 1'b1;
               if (wr_ff) begin
                  rsp_word_in.verdict = (cnt_wide >= 32'(trig_ff)) ? VERDICT_TRIG
                                                                   : VERDICT_BELOW;
                  rsp_word_in.hit_count = cnt_wide[HIT_BITS-1:0];
               end else begin
                  rsp_word_in = res_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         trig_ff      <= '0;
         v4_fill_ff   <= '0;
         v6_fill_ff   <= '0;
         v4_oldest_ff <= '0;
         v6_oldest_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trig_ff      <= trig_in;
         v4_fill_ff   <= v4_fill_in;
         v6_fill_ff   <= v6_fill_in;
         v4_oldest_ff <= v4_oldest_in;
         v6_oldest_ff <= v6_oldest_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      issue_ff    <= issue_in;
      chk_ff      <= chk_in;
      slot_ff     <= slot_in;
      cnt_ff      <= cnt_in;
      wr_ff       <= wr_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

   `SHC_ASSERT(a_fill_max, v4_fill_ff <= FULL && v6_fill_ff <= FULL, "fill count overran table")
   `SHC_ASSERT_IMP(a_v4_oldest_fill, v4_fill_ff < FULL, v4_oldest_ff == '0, "v4 evicted early")
   `SHC_ASSERT_IMP(a_v6_oldest_fill, v6_fill_ff < FULL, v6_oldest_ff == '0, "v6 evicted early")
   `SHC_ASSERT_IMP(a_scan_bound, state_ff == ST_SCAN, issue_ff <= fill_sel, "scan past fill")
   `SHC_ASSERT_IMP(a_chk_bound, state_ff == ST_SCAN && pend_ff, FW'(chk_ff) < fill_sel, "bad chk")

endmodule
